// ----- design/mieu_pkg.sv -----
package mieu_pkg;

  typedef enum logic [4:0] {
    OP_SLL   = 5'd0,  OP_SRL  = 5'd1,  OP_SRA   = 5'd2,  OP_SLLV = 5'd3,
    OP_SRLV  = 5'd4,  OP_SRAV = 5'd5,  OP_ADD   = 5'd6,  OP_SUB  = 5'd7,
    OP_AND   = 5'd8,  OP_OR   = 5'd9,  OP_XOR   = 5'd10, OP_NOR  = 5'd11,
    OP_SLT   = 5'd12, OP_SLTU = 5'd13, OP_ADDI  = 5'd14, OP_SLTI = 5'd15,
    OP_SETLT_IMM_U = 5'd16, OP_ANDI = 5'd17, OP_ORI   = 5'd18, OP_XORI = 5'd19,
    OP_LUI   = 5'd20, OP_MULT = 5'd21, OP_MUL_UNS = 5'd22, OP_DIV  = 5'd23,
    OP_DIVU  = 5'd24, OP_MFHI = 5'd25, OP_MFLO  = 5'd26, OP_MTHI = 5'd27,
    OP_MTLO  = 5'd28
  } op_e;

  localparam logic [31:0] SIGN32 = 32'h8000_0000;
  localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming word
    logic alu_done;  // write ALU result into output register
    logic mul_start; // start multiply (16-bit partial products)
    logic mul_step;
    logic div_start;
    logic div_step;
    logic md_done;   // write HI/LO from the multiply/divide unit
    logic out_pop;   // result word taken downstream
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [4:0] op;
    logic       mul_last;
    logic       div_last;
  } dp_sts_t;

endpackage

// ----- design/mieu_ctrl.sv -----
module mieu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mieu_pkg::dp_sts_t  sts_i,
  output mieu_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_MUL, ST_DIV, ST_FIN} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_valid_i && in_ready_o;
    cmd_o.out_pop   = out_valid_q && out_ready_i;
    cmd_o.mul_start = (state_q == ST_DECODE) &&
                      (sts_i.op == mieu_pkg::OP_MULT || sts_i.op == mieu_pkg::OP_MUL_UNS);
    cmd_o.div_start = (state_q == ST_DECODE) &&
                      (sts_i.op == mieu_pkg::OP_DIV || sts_i.op == mieu_pkg::OP_DIVU);
    cmd_o.alu_done  = (state_q == ST_DECODE) && !cmd_o.mul_start && !cmd_o.div_start;
    cmd_o.mul_step  = (state_q == ST_MUL);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.md_done   = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_pop) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE:   if (cmd_o.load) state_q <= ST_DECODE;
        ST_DECODE: begin
          if (cmd_o.mul_start)      state_q <= ST_MUL;
          else if (cmd_o.div_start) state_q <= ST_DIV;
          else begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        ST_MUL:    if (sts_i.mul_last) state_q <= ST_FIN;
        ST_DIV:    if (sts_i.div_last) state_q <= ST_FIN;
        ST_FIN:    if (out_free) begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/mieu_datapath.sv -----
module mieu_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         op_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  input  logic [15:0]        imm_i,
  input  logic [4:0]         sa_i,
  input  mieu_pkg::dp_cmd_t  cmd_i,
  output mieu_pkg::dp_sts_t  sts_o,
  output logic [31:0]        result_o,
  output logic               wr_o,
  output logic [31:0]        hi_o,
  output logic [31:0]        lo_o
);

  logic [4:0]  op_q;
  logic [31:0] a_q, b_q;
  logic [15:0] imm_q;
  logic [4:0]  sa_q;
  logic [31:0] hi_q, lo_q;
  logic [31:0] res_q;
  logic        wr_q;

  // multiply / divide working registers
  logic [31:0] ma_q, mb_q;       // operand magnitudes
  logic        neg_q, rneg_q;    // negate product/quotient, negate remainder
  logic [1:0]  mcnt_q;
  logic [63:0] acc_q;
  logic [31:0] rem_q, quo_q;
  logic [4:0]  dcnt_q;
  logic        dz_q, dov_q;

  // ALU
  logic [31:0] sext, zext, res_c;
  logic [4:0]  sh;
  logic        signed_op;
  always_comb begin
    sext = {{16{imm_q[15]}}, imm_q};
    zext = {16'd0, imm_q};
    sh   = (op_q == mieu_pkg::OP_SLL || op_q == mieu_pkg::OP_SRL ||
            op_q == mieu_pkg::OP_SRA) ? sa_q : a_q[4:0];
    res_c = '0;
    unique case (op_q)
      mieu_pkg::OP_SLL, mieu_pkg::OP_SLLV: res_c = b_q << sh;
      mieu_pkg::OP_SRL, mieu_pkg::OP_SRLV: res_c = b_q >> sh;
      mieu_pkg::OP_SRA, mieu_pkg::OP_SRAV: res_c = 32'($signed(b_q) >>> sh);
      mieu_pkg::OP_ADD:   res_c = a_q + b_q;
      mieu_pkg::OP_SUB:   res_c = a_q - b_q;
      mieu_pkg::OP_AND:   res_c = a_q & b_q;
      mieu_pkg::OP_OR:    res_c = a_q | b_q;
      mieu_pkg::OP_XOR:   res_c = a_q ^ b_q;
      mieu_pkg::OP_NOR:   res_c = ~(a_q | b_q);
      mieu_pkg::OP_SLT:   res_c = {31'd0, $signed(a_q) < $signed(b_q)};
      mieu_pkg::OP_SLTU:  res_c = {31'd0, a_q < b_q};
      mieu_pkg::OP_ADDI:  res_c = a_q + sext;
      mieu_pkg::OP_SLTI:  res_c = {31'd0, $signed(a_q) < $signed(sext)};
      mieu_pkg::OP_SETLT_IMM_U: res_c = {31'd0, a_q < sext};
      mieu_pkg::OP_ANDI:  res_c = a_q & zext;
      mieu_pkg::OP_ORI:   res_c = a_q | zext;
      mieu_pkg::OP_XORI:  res_c = a_q ^ zext;
      mieu_pkg::OP_LUI:   res_c = {imm_q, 16'd0};
      mieu_pkg::OP_MFHI:  res_c = hi_q;
      mieu_pkg::OP_MFLO:  res_c = lo_q;
      default:            res_c = '0;
    endcase
  end

  logic alu_wr;
  assign alu_wr = (op_q <= mieu_pkg::OP_LUI) || op_q == mieu_pkg::OP_MFHI ||
                  op_q == mieu_pkg::OP_MFLO;
  assign signed_op = (op_q == mieu_pkg::OP_MULT) || (op_q == mieu_pkg::OP_DIV);

  // multiply: four 16x16 partial products, one per cycle
  logic [15:0] pa, pb;
  logic [31:0] pp;
  logic [63:0] pp_sh;
  always_comb begin
    pa = mcnt_q[0] ? ma_q[31:16] : ma_q[15:0];
    pb = mcnt_q[1] ? mb_q[31:16] : mb_q[15:0];
    pp = pa * pb;
    pp_sh = {32'd0, pp} << (6'd16 * ({5'd0, mcnt_q[0]} + {5'd0, mcnt_q[1]}));
  end

  // divide: restoring, one quotient bit per cycle
  logic [32:0] trial;
  logic [31:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[30:0], quo_q[31]};
    trial  = {rem_q, quo_q[31]} - {1'b0, mb_q};
  end

  logic [31:0] ma_c, mb_c;
  assign ma_c = (signed_op && a_q[31]) ? 32'(0 - a_q) : a_q;
  assign mb_c = (signed_op && b_q[31]) ? 32'(0 - b_q) : b_q;

  logic [63:0] prod_f;
  logic [31:0] quo_f, rem_f;
  assign prod_f = neg_q ? 64'(0 - acc_q) : acc_q;
  assign quo_f  = neg_q ? 32'(0 - quo_q) : quo_q;
  assign rem_f  = rneg_q ? 32'(0 - rem_q) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      if (cmd_i.alu_done) begin
        if (op_q == mieu_pkg::OP_MTHI) hi_q <= a_q;
        if (op_q == mieu_pkg::OP_MTLO) lo_q <= a_q;
      end
      if (cmd_i.md_done) begin
        if (op_q == mieu_pkg::OP_MULT || op_q == mieu_pkg::OP_MUL_UNS) begin
          hi_q <= prod_f[63:32];
          lo_q <= prod_f[31:0];
        end else if (dz_q) begin
          hi_q <= a_q;
          lo_q <= (signed_op && a_q[31]) ? 32'd1 : mieu_pkg::MASK32;
        end else if (dov_q) begin
          hi_q <= '0;
          lo_q <= mieu_pkg::SIGN32;
        end else begin
          hi_q <= rem_f;
          lo_q <= quo_f;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; a_q <= a_i; b_q <= b_i; imm_q <= imm_i; sa_q <= sa_i;
    end
    if (cmd_i.alu_done) begin
      res_q <= alu_wr ? res_c : '0;
      wr_q  <= alu_wr;
    end
    if (cmd_i.md_done) begin
      res_q <= '0;
      wr_q  <= 1'b0;
    end
    if (cmd_i.mul_start || cmd_i.div_start) begin
      ma_q   <= ma_c;
      mb_q   <= mb_c;
      neg_q  <= signed_op && (a_q[31] ^ b_q[31]);
      rneg_q <= signed_op && a_q[31];
      mcnt_q <= '0;
      acc_q  <= '0;
      dcnt_q <= '0;
      rem_q  <= '0;
      quo_q  <= ma_c;
      dz_q   <= (b_q == '0);
      dov_q  <= signed_op && a_q == mieu_pkg::SIGN32 && b_q == mieu_pkg::MASK32;
    end
    if (cmd_i.mul_step) begin
      acc_q  <= acc_q + pp_sh;
      mcnt_q <= mcnt_q + 2'd1;
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.mul_last = (mcnt_q == 2'd3);
  assign sts_o.div_last = (dcnt_q == 5'd31);
  assign result_o = res_q;
  assign wr_o     = wr_q;
  assign hi_o     = hi_q;
  assign lo_o     = lo_q;

endmodule

// ----- design/mips_integer_execute_unit.sv -----
// Integer execute unit of a MIPS-I core with HI/LO. Input word tdata, low bit up:
// op[4:0], a_operand[36:5], b_operand[68:37], immediate[84:69], shift_amount[89:85].
// Output word tdata: result[31:0], writes_register[32], hi_value[64:33],
// lo_value[96:65]. One word at a time: ALU ops and moves write the result from the
// decode state; mult/multu sum four 16x16 partial products through one multiplier,
// div/divu run a restoring divider, one quotient bit a cycle.
// The next word is taken once the block is back in idle and the output slot is free.
module mips_integer_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // op, a_operand, b_operand, immediate, shift_amount
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // result, writes_register, hi_value, lo_value
);

  mieu_pkg::dp_cmd_t cmd;
  mieu_pkg::dp_sts_t sts;
  logic [31:0] result, hi, lo;
  logic        wr;

  mieu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mieu_datapath u_dp (
    .clk_i, .rst_ni,
    .op_i    (s_axis_tdata[4:0]),
    .a_i     (s_axis_tdata[36:5]),
    .b_i     (s_axis_tdata[68:37]),
    .imm_i   (s_axis_tdata[84:69]),
    .sa_i    (s_axis_tdata[89:85]),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .result_o(result),
    .wr_o    (wr),
    .hi_o    (hi),
    .lo_o    (lo)
  );

  assign m_axis_tdata = {7'd0, lo, hi, wr, result};

  // accept only when idle and output slot free
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted back-to-back");
  a_nowr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("result nonzero without write");

endmodule
